// File: hdl/rcrt_pkg.sv
`timescale 1ns / 1ps
// Package for the ring completion retire tracker: item types, codes, FSM state.
// No dependencies; used by rcrt_mod and ring_completion_retire_tracker_unit.
package rcrt_pkg;

	localparam int CNT_W = 11;
	localparam int SUM_W = 12;

	localparam logic [CNT_W-1:0] CNT_MAX        = 11'h7FF;
	localparam logic [CNT_W-1:0] RING_SLOTS_RST = 11'd1024;
	localparam logic [CNT_W-1:0] SLOTS_MIN      = 11'd2;

	localparam logic CMD_MARK   = 1'b0;
	localparam logic CMD_RETIRE = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	typedef struct packed {
		logic       command;
		logic [1:0] ring_id;
		logic [9:0] start_slot;
		logic [9:0] end_slot;
	} rcrt_in_t;

	typedef struct packed {
		logic             status;
		logic [CNT_W-1:0] released_count;
		logic [9:0]       head_slot;
	} rcrt_out_t;

	// request and response of the modulo unit
	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
	} rcrt_mod_req_t;

	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] remainder;
	} rcrt_mod_rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_MOD,
		ST_RESP
	} rcrt_state_t;

endpackage

// File: hdl/rcrt_mod.sv
`timescale 1ns / 1ps
// Iterative modulo unit: one compare and subtract per cycle.
// Depends on rcrt_pkg.
module rcrt_mod import rcrt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  rcrt_mod_req_t    req,
	input  logic [CNT_W-1:0] divisor,
	output rcrt_mod_rsp_t    rsp
);

	logic             busy_q;
	logic [SUM_W-1:0] rem_q;
	logic             below;

	assign below = rem_q < SUM_W'(divisor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (busy_q && below) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend;
		end else if (busy_q && !below) begin
			rem_q <= rem_q - SUM_W'(divisor);
		end
	end

	assign rsp.done      = busy_q && below;
	assign rsp.remainder = rem_q[CNT_W-1:0];

endmodule

// File: hdl/ring_completion_retire_tracker_unit.sv
`timescale 1ns / 1ps
// Ring completion retire tracker, top level. Depends on rcrt_pkg and rcrt_mod.
// Flow: a mark passes IDLE, DECODE (table write) and RESP; a retire passes DECODE and,
// per run walked, WALK_RD, WALK_CHK and MOD (one modulo subtraction when the jump wraps),
// then RESP. A new item is taken only in IDLE, once the previous one has left RESP.
// Reset: async, active low; then a clearing pass over all RINGS*SLOTS entries
// (4096 by default) zeroes the single-port run-length table while in_stall stays high.
module ring_completion_retire_tracker_unit import rcrt_pkg::*; #(
	parameter int RINGS = 4,
	parameter int SLOTS = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  rcrt_in_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output rcrt_out_t        out_data
);

	localparam int SW    = $clog2(SLOTS);
	localparam int RIW   = (RINGS > 1) ? $clog2(RINGS) : 1;
	localparam int DEPTH = RINGS * SLOTS;
	localparam int AW    = $clog2(DEPTH);

	// configuration
	logic [CNT_W-1:0] ring_slots_q;
	logic [CNT_W-1:0] n_eff;

	// control
	rcrt_state_t      state_q, state_d;
	logic [AW-1:0]    clr_q;
	rcrt_in_t         item_q;
	rcrt_out_t        res_q;
	logic             out_valid_q;
	rcrt_out_t        out_q;

	// walk datapath
	logic [SW-1:0]    head_q [RINGS];
	logic [SW-1:0]    h_q;
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] steps_q;

	// run-length table
	logic [CNT_W-1:0] mem [DEPTH];
	logic             mem_we;
	logic             mem_re;
	logic [AW-1:0]    mem_addr;
	logic [CNT_W-1:0] mem_wdata;
	logic [CNT_W-1:0] rd_data_q;

	rcrt_mod_req_t    mod_req;
	rcrt_mod_rsp_t    mod_rsp;

	// decode
	logic             ring_ok;
	logic [RIW-1:0]   ring_ix;
	logic [SW-1:0]    head_cur;
	logic             is_mark;
	logic             mark_bad;
	logic             head_bad;
	logic [CNT_W-1:0] mark_len;
	logic [AW-1:0]    base_addr;
	logic             walk_end_rd;
	logic             walk_end_chk;
	logic             out_free;
	logic [SUM_W-1:0] tot_sum;
	logic [CNT_W-1:0] tot_next;

	// effective slot count, clamped to [2, SLOTS]
	always_comb begin
		priority if (ring_slots_q < SLOTS_MIN) begin
			n_eff = SLOTS_MIN;
		end else if (32'(ring_slots_q) > SLOTS) begin
			n_eff = CNT_W'(SLOTS);
		end else begin
			n_eff = ring_slots_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_slots_q <= RING_SLOTS_RST;
		end else if (cfg_we) begin
			ring_slots_q <= cfg_wdata;
		end
	end

	assign ring_ok   = 32'(item_q.ring_id) < RINGS;
	assign ring_ix   = RIW'(item_q.ring_id);
	assign head_cur  = head_q[ring_ix];
	assign is_mark   = item_q.command == CMD_MARK;
	assign mark_bad  = (CNT_W'(item_q.start_slot) >= n_eff) ||
	                   (CNT_W'(item_q.end_slot) >= n_eff);
	assign head_bad  = CNT_W'(head_cur) >= n_eff;
	assign base_addr = AW'(ring_ix) * AW'(SLOTS);

	// wrapped range length
	always_comb begin
		if (item_q.start_slot <= item_q.end_slot) begin
			mark_len = CNT_W'(item_q.end_slot) - CNT_W'(item_q.start_slot) + CNT_W'(1);
		end else begin
			mark_len = n_eff - (CNT_W'(item_q.start_slot) - CNT_W'(item_q.end_slot)
			           - CNT_W'(1));
		end
	end

	assign walk_end_rd  = steps_q == n_eff;
	assign walk_end_chk = rd_data_q == '0;
	assign out_free     = !out_valid_q || !out_stall;
	assign tot_sum      = SUM_W'(total_q) + SUM_W'(rd_data_q);
	assign tot_next     = (tot_sum > SUM_W'(CNT_MAX)) ? CNT_MAX : tot_sum[CNT_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (ring_ok && !is_mark && !head_bad) state_d = ST_WALK_RD;
				else state_d = ST_RESP;
			end
			ST_WALK_RD: begin
				if (walk_end_rd) state_d = ST_RESP;
				else state_d = ST_WALK_CHK;
			end
			ST_WALK_CHK: begin
				if (walk_end_chk) state_d = ST_RESP;
				else state_d = ST_MOD;
			end
			ST_MOD: begin
				if (mod_rsp.done) state_d = ST_WALK_RD;
			end
			ST_RESP: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// state outputs: handshake, table port, modulo start
	always_comb begin
		in_stall         = 1'b1;
		mem_we           = 1'b0;
		mem_re           = 1'b0;
		mem_addr         = base_addr + AW'(h_q);
		mem_wdata        = '0;
		mod_req.start    = 1'b0;
		mod_req.dividend = SUM_W'(h_q) + SUM_W'(rd_data_q);
		unique case (state_q)
			ST_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_DECODE: begin
				mem_addr  = base_addr + AW'(item_q.start_slot);
				mem_wdata = mark_len;
				mem_we    = ring_ok && is_mark && !mark_bad;
			end
			ST_WALK_RD: begin
				mem_re = !walk_end_rd;
			end
			ST_WALK_CHK: begin
				// retire the run: clear its entry and jump over it
				mem_we        = !walk_end_chk;
				mod_req.start = !walk_end_chk;
			end
			ST_MOD, ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	rcrt_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mod_req),
		.divisor (n_eff),
		.rsp     (mod_rsp)
	);

	// table, single port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		if (mem_re) rd_data_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			for (int r = 0; r < RINGS; r++) head_q[r] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (state_q == ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			// walk finished: commit the new head
			if ((state_q == ST_WALK_RD && walk_end_rd) ||
			    (state_q == ST_WALK_CHK && walk_end_chk)) begin
				head_q[ring_ix] <= h_q;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) item_q <= in_data;
		if (state_q == ST_RESP && out_free) out_q <= res_q;
		unique case (state_q)
			ST_DECODE: begin
				h_q     <= head_cur;
				total_q <= '0;
				steps_q <= '0;
				if (!ring_ok) begin
					res_q <= '{status: STATUS_RANGE, released_count: '0, head_slot: '0};
				end else if ((is_mark && mark_bad) || (!is_mark && head_bad)) begin
					res_q <= '{status: STATUS_RANGE, released_count: '0,
					           head_slot: 10'(head_cur)};
				end else begin
					res_q <= '{status: STATUS_OK, released_count: '0,
					           head_slot: 10'(head_cur)};
				end
			end
			ST_WALK_RD: begin
				if (walk_end_rd) begin
					res_q <= '{status: STATUS_OK, released_count: total_q,
					           head_slot: 10'(h_q)};
				end
			end
			ST_WALK_CHK: begin
				if (walk_end_chk) begin
					res_q <= '{status: STATUS_OK, released_count: total_q,
					           head_slot: 10'(h_q)};
				end else begin
					total_q <= tot_next;
					steps_q <= steps_q + CNT_W'(1);
				end
			end
			ST_MOD: begin
				if (mod_rsp.done) h_q <= SW'(mod_rsp.remainder);
			end
			ST_CLEAR, ST_IDLE, ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// a new result only comes out of the response state
	a_out_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_RESP))
		else $error("result appeared outside the response state");

	// the walk head always stays inside the ring
	a_head_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK_RD) |-> (CNT_W'(h_q) < n_eff))
		else $error("walk head beyond ring size");

	// the walk never visits more than n entries
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK_RD || state_q == ST_WALK_CHK || state_q == ST_MOD)
		|-> (steps_q <= n_eff))
		else $error("walk exceeded its step bound");

	// a rejected item releases nothing
	a_range_no_release: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == STATUS_RANGE)
		|-> (out_data.released_count == '0))
		else $error("out-of-range item released slots");

endmodule

// File: sim/ring_completion_retire_tracker_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for ring_completion_retire_tracker_unit: directed and random mark/retire items,
// checked one by one against an in-bench model of the run-length table and retire heads.
// Depends on rcrt_pkg and the tracker RTL.
module ring_completion_retire_tracker_unit_tb;
	import rcrt_pkg::*;

	localparam int RING_CNT         = 4;
	localparam int SLOT_CNT         = 1024;
	localparam int MAX_GAP          = 11;
	localparam int SETTLE_CYCLES    = 64;     // idle time before a register write / the end
	localparam int LONG_HOLD_CYCLES = 300;    // receiver hold-off that backs up the input
	localparam int LIMIT_CYCLES     = 1000000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cfg_we    = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = RING_SLOTS_RST;
	logic      in_valid  = 1'b0;
	logic      in_stall;
	rcrt_in_t  in_data   = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	rcrt_out_t out_data;

	ring_completion_retire_tracker_unit #(
		.RINGS(RING_CNT),
		.SLOTS(SLOT_CNT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Tracker model: per-ring run lengths, retire heads and the slot count
	// register. Updated once per accepted item, in acceptance order.
	// ------------------------------------------------------------------
	logic [CNT_W-1:0] run_len [RING_CNT][SLOT_CNT];
	logic [9:0]       head_of [RING_CNT];
	logic [CNT_W-1:0] slots_cfg;

	rcrt_out_t pending_results [$];   // expected results, oldest first
	int unsigned errors      = 0;
	int unsigned sent_items  = 0;
	int unsigned cycle_count = 0;

	// sender / receiver idling controls
	bit tx_steady = 1'b0;             // sender offers items back to back
	bit rx_steady = 1'b0;             // receiver never stalls on its own
	int unsigned hold_reqs = 0;       // long hold-offs requested by the tests
	int unsigned hold_done = 0;       // long hold-offs started by the receiver
	int unsigned rx_left   = 0;       // stall cycles still to go
	int unsigned rx_draw;

	function automatic void clear_tracker_model();
		for (int r = 0; r < RING_CNT; r++) begin
			head_of[r] = '0;
			for (int s = 0; s < SLOT_CNT; s++)
				run_len[r][s] = '0;
		end
		slots_cfg = RING_SLOTS_RST;
	endfunction

	// register value clamped into [2, SLOT_CNT]
	function automatic int unsigned live_slots();
		if (slots_cfg < SLOTS_MIN)
			return 32'(SLOTS_MIN);
		if (32'(slots_cfg) > SLOT_CNT)
			return SLOT_CNT;
		return 32'(slots_cfg);
	endfunction

	function automatic rcrt_out_t predict_tracker_result(input rcrt_in_t it);
		rcrt_out_t   r;
		int unsigned n, h, v, total, steps, s, e;
		n = live_slots();
		h = 32'(head_of[it.ring_id]);
		s = 32'(it.start_slot);
		e = 32'(it.end_slot);
		r.status         = STATUS_OK;
		r.released_count = '0;
		r.head_slot      = 10'(h);
		if (it.command == CMD_MARK) begin
			if (s >= n || e >= n) begin
				r.status = STATUS_RANGE;
			end else begin
				// wrapped range covers start..n-1 and 0..end
				run_len[it.ring_id][s] = CNT_W'((s <= e) ? (e - s + 1) : (n - (s - e - 1)));
			end
		end else if (h >= n) begin
			// head left over from a larger ring size
			r.status = STATUS_RANGE;
		end else begin
			total = 0;
			steps = 0;
			while (steps < n) begin
				v = 32'(run_len[it.ring_id][h]);
				if (v == 0)
					break;
				run_len[it.ring_id][h] = '0;
				h = (h + v) % n;
				total += v;
				if (total > 32'(CNT_MAX))
					total = 32'(CNT_MAX);
				steps++;
			end
			head_of[it.ring_id] = 10'(h);
			r.released_count    = CNT_W'(total);
			r.head_slot         = 10'(h);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	// ------------------------------------------------------------------
	// Result checker: every accepted output item against the oldest
	// expectation, field by field.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		rcrt_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result item with none expected", 32'(out_data), 0);
			end else begin
				want = pending_results.pop_front();
				if (out_data.status !== want.status)
					report_mismatch("status", 32'(out_data.status), 32'(want.status));
				if (out_data.released_count !== want.released_count)
					report_mismatch("released_count", 32'(out_data.released_count),
						32'(want.released_count));
				if (out_data.head_slot !== want.head_slot)
					report_mismatch("head_slot", 32'(out_data.head_slot),
						32'(want.head_slot));
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: after each taken item, stall for a random draw from 0..MAX_GAP. A test
	// may ask for one long hold-off, counted here.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_reqs != hold_done) begin
			hold_done <= hold_reqs;
			rx_left   <= LONG_HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (out_valid && !out_stall) begin
			rx_draw = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
			rx_left   <= rx_draw;
			out_stall <= (rx_draw != 0);
		end else if (rx_left != 0) begin
			rx_left   <= rx_left - 1;
			out_stall <= (rx_left > 1);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("ring_completion_retire_tracker_unit: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sender helpers. All are entered right after a rising edge.
	// ------------------------------------------------------------------

	// offer one item after a random gap, wait for acceptance, queue its result
	task automatic issue_item(input logic cmd, input logic [1:0] ring,
			input logic [9:0] s, input logic [9:0] e);
		rcrt_in_t    it;
		int unsigned gap;
		it.command    = cmd;
		it.ring_id    = ring;
		it.start_slot = s;
		it.end_slot   = e;
		gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(predict_tracker_result(it));
		sent_items++;
	endtask

	// stop offering, wait for every outstanding result, then let the block settle
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_ring_slots(input logic [CNT_W-1:0] value);
		wait_results_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		slots_cfg = value;
	endtask

	// contiguous runs from the ring's head, marked out of order, sometimes with
	// one run left out so the walk stops short, then a retire
	task automatic mark_chain_and_retire(input logic [1:0] ring);
		int unsigned n, pos, cnt, len, drop, tmp;
		int          j, k;
		logic [9:0]  st [8];
		logic [9:0]  en [8];
		n   = live_slots();
		pos = 32'(head_of[ring]);
		if (pos >= n) begin
			issue_item(CMD_RETIRE, ring, 10'($urandom_range(0, 1023)),
				10'($urandom_range(0, 1023)));
			return;
		end
		cnt = $urandom_range(1, 8);
		for (j = 0; j < cnt; j++) begin
			if ($urandom_range(0, 15) == 0)
				len = $urandom_range(1, n);
			else
				len = $urandom_range(1, (n < 8) ? n : 8);
			st[j] = 10'(pos);
			en[j] = 10'((pos + len - 1) % n);
			pos   = (pos + len) % n;
		end
		for (j = cnt - 1; j > 0; j--) begin
			k = $urandom_range(0, j);
			tmp = 32'(st[j]); st[j] = st[k]; st[k] = 10'(tmp);
			tmp = 32'(en[j]); en[j] = en[k]; en[k] = 10'(tmp);
		end
		drop = ($urandom_range(0, 4) == 0) ? $urandom_range(0, cnt - 1) : cnt;
		for (j = 0; j < cnt; j++)
			if (j != drop)
				issue_item(CMD_MARK, ring, st[j], en[j]);
		issue_item(CMD_RETIRE, ring, 10'($urandom_range(0, 1023)),
			10'($urandom_range(0, 1023)));
	endtask

	// anything at all: random command, ring and slots, in or out of range
	task automatic issue_noise_item();
		int unsigned n;
		logic [9:0]  s, e;
		n = live_slots();
		if ($urandom_range(0, 1)) begin
			s = 10'($urandom_range(0, 1023));
			e = 10'($urandom_range(0, 1023));
		end else begin
			s = 10'($urandom_range(0, n - 1));
			e = 10'($urandom_range(0, n - 1));
		end
		issue_item(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), s, e);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// empty retire, single-slot run, longest plain run, walk that wraps to 0
	task automatic test_basic_walk();
		issue_item(CMD_RETIRE, 2'd0, 10'd0, 10'd0);
		issue_item(CMD_MARK, 2'd0, 10'd0, 10'd0);
		issue_item(CMD_MARK, 2'd0, 10'd1, 10'd1023);
		issue_item(CMD_RETIRE, 2'd0, 10'h3FF, 10'h3FF);
	endtask

	// a second mark at the same start replaces the first length
	task automatic test_overwrite();
		issue_item(CMD_MARK, 2'd1, 10'd0, 10'd9);
		issue_item(CMD_MARK, 2'd1, 10'd0, 10'd3);
		issue_item(CMD_RETIRE, 2'd1, 10'd0, 10'd0);
	endtask

	// slots at or past the ring size; a wrapped range covering the whole ring
	task automatic test_slot_range();
		write_ring_slots(11'd600);
		issue_item(CMD_MARK, 2'd2, 10'd600, 10'd0);
		issue_item(CMD_MARK, 2'd2, 10'd0, 10'd1023);
		issue_item(CMD_MARK, 2'd2, 10'd0, 10'd299);
		issue_item(CMD_MARK, 2'd2, 10'd300, 10'd299);
		issue_item(CMD_RETIRE, 2'd2, 10'd0, 10'd0);
	endtask

	// register above the top clamps to 1024; three near-full runs saturate the count
	task automatic test_released_saturation();
		write_ring_slots(11'h7FF);
		issue_item(CMD_MARK, 2'd3, 10'd0, 10'd1022);
		issue_item(CMD_MARK, 2'd3, 10'd1023, 10'd1021);
		issue_item(CMD_MARK, 2'd3, 10'd1022, 10'd1020);
		issue_item(CMD_RETIRE, 2'd3, 10'd0, 10'd0);
	endtask

	// register below the bottom clamps to 2; ring 3's head is now past the ring
	task automatic test_stale_head();
		write_ring_slots(11'd0);
		issue_item(CMD_RETIRE, 2'd3, 10'd0, 10'd0);
		issue_item(CMD_MARK, 2'd3, 10'd1, 10'd0);
		write_ring_slots(11'd1);
		issue_item(CMD_MARK, 2'd0, 10'd1, 10'd1);
		issue_item(CMD_MARK, 2'd0, 10'd0, 10'd0);
		issue_item(CMD_RETIRE, 2'd0, 10'd0, 10'd0);
	endtask

	// receiver holds off for a long stretch while the sender keeps offering
	task automatic test_backpressure();
		int unsigned stop_at;
		write_ring_slots(11'd64);
		tx_steady = 1'b1;
		hold_reqs++;
		stop_at = sent_items + 40;
		while (sent_items < stop_at)
			mark_chain_and_retire(2'($urandom_range(0, 3)));
		tx_steady = 1'b0;
		wait_results_drained();
	endtask

	// mostly well-formed chains, some noise, over a spread of ring sizes
	task automatic test_random_phases();
		int unsigned slots_plan [10] = '{8, 2, 37, 3, 1000, 513, 2047, 0, 1, 1024};
		int unsigned items_plan [10] = '{220, 180, 220, 180, 260, 200, 200, 40, 40, 260};
		int unsigned stop_at;
		for (int p = 0; p < 10; p++) begin
			write_ring_slots(CNT_W'(slots_plan[p]));
			stop_at = sent_items + items_plan[p];
			while (sent_items < stop_at) begin
				// stretches with no idling on one side or the other
				if ($urandom_range(0, 39) == 0)
					tx_steady = !tx_steady;
				if ($urandom_range(0, 39) == 0)
					rx_steady = !rx_steady;
				if ($urandom_range(0, 99) < 70)
					mark_chain_and_retire(2'($urandom_range(0, 3)));
				else
					issue_noise_item();
			end
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	initial begin
		clear_tracker_model();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// table clearing pass keeps the input stalled
		do @(posedge clk); while (in_stall);

		test_basic_walk();
		test_overwrite();
		test_slot_range();
		test_released_saturation();
		test_stale_head();
		test_backpressure();
		test_random_phases();

		wait_results_drained();
		if (errors == 0) begin
			$display("ring_completion_retire_tracker_unit: match");
		end else begin
			$display("ring_completion_retire_tracker_unit: mismatch");
		end
		$finish;
	end

endmodule

// File: ring_completion_retire_tracker_unit.f
hdl/rcrt_pkg.sv
hdl/rcrt_mod.sv
hdl/ring_completion_retire_tracker_unit.sv
sim/ring_completion_retire_tracker_unit_tb.sv
